>>> hdl/au_pkg.sv
// ----------------------------------------------------------------------------
// au_pkg
// Types and constants shared by the AU stream decoder modules.
// ----------------------------------------------------------------------------
package au_pkg;

	localparam int QUEUE_DEPTH = 2;
	localparam logic [31:0] HDR_BYTES = 32'd24;
	localparam logic [3:0][7:0] MAGIC = {8'h64, 8'h6E, 8'h73, 8'h2E};  // ".snd"
	localparam logic [31:0] ENC_MULAW = 32'd1;
	localparam logic [31:0] ENC_LINEAR8 = 32'd2;

	typedef enum logic [2:0] {
		PH_HEADER = 3'd0,
		PH_SKIP   = 3'd1,
		PH_DATA   = 3'd2,
		PH_DONE   = 3'd3,
		PH_ERROR  = 3'd4
	} phase_t;

	typedef enum logic [2:0] {
		RK_SAMPLE    = 3'd0,
		RK_HDR_OK    = 3'd1,
		RK_BAD_MAGIC = 3'd2,
		RK_BAD_ENC   = 3'd3,
		RK_BAD_CHAN  = 3'd4
	} kind_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       start_of_file;
	} item_t;

	typedef struct packed {
		logic [2:0]         result_kind;
		logic signed [15:0] sample;
		logic [31:0]        sample_rate;
		logic [1:0]         channel_count;
		logic               is_linear8;
		logic               last_sample;
	} result_t;

	// classified beat handed from parser to expander
	typedef struct packed {
		kind_t       kind;
		logic [7:0]  data_byte;
		logic [31:0] rate;
		logic [1:0]  channels;
		logic        linear8;
		logic        last;
	} op_t;

endpackage

>>> hdl/au_parse.sv
// ----------------------------------------------------------------------------
// au_parse
// Header parser: checks magic, captures header words, skips to the data
// region and classifies each byte into an operation for the expander.
// ----------------------------------------------------------------------------
module au_parse (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           accept,
	input  au_pkg::item_t  item,
	output logic           push,
	output au_pkg::op_t    op
);

	au_pkg::phase_t phase_q, phase_d, eff_phase;
	logic [31:0] offset_q, offset_d, eff_off, off_inc;
	logic [31:0] hdr_len_q, hdr_len_d, eff_hl, hl_floor;
	logic [31:0] remain_q, remain_d, eff_rem;
	logic [31:0] enc_q, enc_d, eff_enc;
	logic [31:0] rate_q, rate_d, eff_rate;
	logic [31:0] chan_q, chan_d, eff_chan;
	logic [7:0]  b;
	logic        linear;

	assign b = item.data_byte;

	always_comb begin
		if (item.start_of_file) begin
			eff_phase = au_pkg::PH_HEADER;
			eff_off   = '0;
			eff_hl    = '0;
			eff_rem   = '0;
			eff_enc   = '0;
			eff_rate  = '0;
			eff_chan  = '0;
		end else begin
			eff_phase = phase_q;
			eff_off   = offset_q;
			eff_hl    = hdr_len_q;
			eff_rem   = remain_q;
			eff_enc   = enc_q;
			eff_rate  = rate_q;
			eff_chan  = chan_q;
		end
	end

	// saturating offset
	assign off_inc = (eff_off == '1) ? eff_off : eff_off + 32'd1;

	always_comb begin
		phase_d   = eff_phase;
		offset_d  = off_inc;
		hdr_len_d = eff_hl;
		remain_d  = eff_rem;
		enc_d     = eff_enc;
		rate_d    = eff_rate;
		chan_d    = eff_chan;
		push      = 1'b0;
		op        = '0;
		hl_floor  = '0;
		linear    = 1'b0;

		case (eff_phase)
			au_pkg::PH_HEADER: begin
				if (eff_off < 32'd4) begin
					if (b != au_pkg::MAGIC[eff_off[1:0]]) begin
						phase_d  = au_pkg::PH_ERROR;
						offset_d = eff_off;
						push     = 1'b1;
						op.kind  = au_pkg::RK_BAD_MAGIC;
					end
				end else if (eff_off < 32'd8) begin
					hdr_len_d = {eff_hl[23:0], b};
				end else if (eff_off < 32'd12) begin
					remain_d = {eff_rem[23:0], b};
				end else if (eff_off < 32'd16) begin
					enc_d = {eff_enc[23:0], b};
				end else if (eff_off < 32'd20) begin
					rate_d = {eff_rate[23:0], b};
				end else begin
					chan_d = {eff_chan[23:0], b};
				end

				if (eff_off == au_pkg::HDR_BYTES - 32'd1) begin
					push   = 1'b1;
					linear = (enc_d == au_pkg::ENC_LINEAR8);
					if (enc_d != au_pkg::ENC_MULAW && !linear) begin
						phase_d = au_pkg::PH_ERROR;
						op.kind = au_pkg::RK_BAD_ENC;
					end else if (chan_d != 32'd1 && chan_d != 32'd2) begin
						phase_d = au_pkg::PH_ERROR;
						op.kind = au_pkg::RK_BAD_CHAN;
					end else begin
						hl_floor  = (hdr_len_d < au_pkg::HDR_BYTES) ? au_pkg::HDR_BYTES
							: hdr_len_d;
						hdr_len_d = hl_floor;
						if (au_pkg::HDR_BYTES < hl_floor) begin
							phase_d = au_pkg::PH_SKIP;
						end else if (remain_d == '0) begin
							phase_d = au_pkg::PH_DONE;
						end else begin
							phase_d = au_pkg::PH_DATA;
						end
						op.kind     = au_pkg::RK_HDR_OK;
						op.rate     = rate_d;
						op.channels = chan_d[1:0];
						op.linear8  = linear;
					end
				end
			end
			au_pkg::PH_SKIP: begin
				if (off_inc >= eff_hl) begin
					phase_d = (eff_rem == '0) ? au_pkg::PH_DONE : au_pkg::PH_DATA;
				end
			end
			au_pkg::PH_DATA: begin
				if (eff_rem == '0) begin
					phase_d = au_pkg::PH_DONE;
				end else begin
					remain_d     = eff_rem - 32'd1;
					push         = 1'b1;
					op.kind      = au_pkg::RK_SAMPLE;
					op.data_byte = b;
					op.linear8   = (eff_enc == au_pkg::ENC_LINEAR8);
					op.last      = (eff_rem == 32'd1);
					if (eff_rem == 32'd1) begin
						phase_d = au_pkg::PH_DONE;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= au_pkg::PH_HEADER;
			offset_q  <= '0;
			hdr_len_q <= '0;
			remain_q  <= '0;
			enc_q     <= '0;
			rate_q    <= '0;
			chan_q    <= '0;
		end else if (accept) begin
			phase_q   <= phase_d;
			offset_q  <= offset_d;
			hdr_len_q <= hdr_len_d;
			remain_q  <= remain_d;
			enc_q     <= enc_d;
			rate_q    <= rate_d;
			chan_q    <= chan_d;
		end
	end

endmodule

>>> hdl/au_queue.sv
// ----------------------------------------------------------------------------
// au_queue
// Small register FIFO between the parser and the expander.
// ----------------------------------------------------------------------------
module au_queue #(
	parameter int DEPTH = au_pkg::QUEUE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  au_pkg::op_t  push_op,
	input  logic         pop,
	output au_pkg::op_t  head,
	output logic         empty,
	output logic         full
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	au_pkg::op_t   mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push, do_pop;

	assign empty   = (count_q == '0);
	assign full    = (count_q == FULL_CNT);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

>>> hdl/au_expand.sv
// ----------------------------------------------------------------------------
// au_expand
// Back end: turns queued operations into result beats, expanding mu-law
// codes, and holds each beat in the output register until taken.
// ----------------------------------------------------------------------------
module au_expand (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            op_avail,
	input  au_pkg::op_t     op,
	output logic            pop,
	output logic            result_valid,
	input  logic            result_stall,
	output au_pkg::result_t result
);

	// eight-segment expansion, scaled by four
	function automatic logic [15:0] mulaw(input logic [7:0] code);
		logic [3:0]  inv;
		logic [13:0] mag;
		inv = ~code[3:0];
		mag = '0;
		case (code[6:4])
			3'd7: mag = 14'({inv, 1'b0});
			3'd6: mag = 14'({inv, 2'b0}) + 14'd32;
			3'd5: mag = 14'({inv, 3'b0}) + 14'd96;
			3'd4: mag = 14'({inv, 4'b0}) + 14'd224;
			3'd3: mag = 14'({inv, 5'b0}) + 14'd480;
			3'd2: mag = 14'({inv, 6'b0}) + 14'd992;
			3'd1: mag = 14'({inv, 7'b0}) + 14'd2016;
			default: begin
				// code 0x80 or 0x00 sits outside the segment table
				mag = (code[3:0] == 4'd0) ? 14'd255 : 14'({inv, 8'b0}) + 14'd4064;
			end
		endcase
		return code[7] ? {mag, 2'b00} : 16'(-{mag, 2'b00});
	endfunction

	au_pkg::result_t next;
	logic            valid_q;

	assign pop          = op_avail && (!valid_q || !result_stall);
	assign result_valid = valid_q;

	always_comb begin
		next               = '0;
		next.result_kind   = op.kind;
		next.sample_rate   = op.rate;
		next.channel_count = op.channels;
		next.is_linear8    = op.linear8;
		next.last_sample   = op.last;
		if (op.kind == au_pkg::RK_SAMPLE) begin
			next.sample = op.linear8 ? {8'd0, op.data_byte} : mulaw(op.data_byte);
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			result <= next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (!result_stall) begin
			valid_q <= 1'b0;
		end
	end

endmodule

>>> hdl/au_ulaw_stream_decoder.sv
// ----------------------------------------------------------------------------
// au_ulaw_stream_decoder
// AU sound file parser and mu-law / 8-bit linear sample decoder.
// ----------------------------------------------------------------------------
// Usage:
//   The file arrives one byte per beat on item (valid/stall). start_of_file
//   marks the first byte of a file and restarts the parser; after reset the
//   first byte is treated as a file start anyway.
//   Each byte yields at most one beat on result: a header verdict after the
//   24th byte (or at a bad magic byte), then one sample per data byte.
//   Header padding and bytes past the data region produce nothing.
//   Throughput: one byte per cycle sustained; the parser takes a byte every
//   cycle while the queue has room.
//   Each accepted byte's beat is written into the queue, then loaded into
//   the output register when the expander pops it.
//   Reset clears the parser, the queue count and pointers, and valid_q.
//   When result is stalled the output register holds; the queue absorbs
//   QUEUE_DEPTH beats, after which item is stalled.
// ----------------------------------------------------------------------------
module au_ulaw_stream_decoder #(
	parameter int QUEUE_DEPTH = au_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_stall,
	input  au_pkg::item_t   item,
	output logic            result_valid,
	input  logic            result_stall,
	output au_pkg::result_t result
);

	logic        accept, push, pop, empty, full;
	au_pkg::op_t push_op, head;

	assign item_stall = full;
	assign accept     = item_valid && !full;

	au_parse u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.item   (item),
		.push   (push),
		.op     (push_op)
	);

	au_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push && accept),
		.push_op (push_op),
		.pop     (pop),
		.head    (head),
		.empty   (empty),
		.full    (full)
	);

	au_expand u_expand (
		.clk          (clk),
		.arst_n       (arst_n),
		.op_avail     (!empty),
		.op           (head),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule
